// ===== hdl/rv32im_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv32im_pkg: shared types and constants for the RV32IM execute unit
// Opcodes, status codes, sequencer states and memory geometry.
// ----------------------------------------------------------------------------
package rv32im_pkg;

	localparam int MEM_WORDS = 16384;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int REG_COUNT = 32;
	localparam int REG_AW    = $clog2(REG_COUNT);

	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MEXT = 7'h01;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [2:0] F3_BYTE  = 3'd0;
	localparam logic [2:0] F3_HALF  = 3'd1;
	localparam logic [2:0] F3_WORD  = 3'd2;
	localparam logic [2:0] F3_BYTEU = 3'd4;
	localparam logic [2:0] F3_HALFU = 3'd5;

	typedef enum logic [1:0] {
		STS_OK         = 2'd0,
		STS_ILLEGAL    = 2'd1,
		STS_MISALIGNED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_MEM,
		S_MULFIN,
		S_DIV,
		S_DIVFIN
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/rv32im_execute_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv32im_execute_unit: RV32IM execute stage with register file and data RAM
// Runs one decoded instruction at a time against a synchronous register
// file and a synchronous word RAM, with a shared iterative divider.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------------------------
//  req     | req_valid, req_stall, op..pc_in  | instruction beat in
//  rsp     | rsp_valid, rsp_stall, pc_out..   | result beat out
//
//  ALU, branch and jump ops finish in S_EXEC; loads and stores go on to
//  S_MEM (a faulting one finishes in S_EXEC), multiplies to S_MULFIN, and
//  divide and remainder step through S_DIV (one quotient bit per cycle)
//  and S_DIVFIN. S_EXEC uses the registered register file read; S_MEM
//  uses the registered RAM read.
//  After reset a clearing pass over all MEM_WORDS (16384) RAM words zeroes
//  the RAM and register file; req_stall stays high during it.
//  A result waits in the output register; a new beat is accepted meanwhile,
//  but its result is held back until the output register frees.
//
module rv32im_execute_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [6:0]  op,
	input  wire logic [2:0]  funct3,
	input  wire logic [6:0]  funct7,
	input  wire logic [4:0]  src1_index,
	input  wire logic [4:0]  src2_index,
	input  wire logic [4:0]  dest_index,
	input  wire logic [31:0] immediate,
	input  wire logic [31:0] pc_in,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [31:0]      pc_out,
	output logic             writeback_valid,
	output logic [31:0]      writeback_value,
	output logic [1:0]       status
);

	localparam logic [6:0] F7_ALT_C = rv32im_pkg::F7_ALT;

	rv32im_pkg::state_t state_q, state_nx;

	// latched instruction
	logic [6:0]  op_q;
	logic [2:0]  f3_q;
	logic [6:0]  f7_q;
	logic [4:0]  rd_q;
	logic [31:0] imm_q;
	logic [31:0] pc_q;

	// register file: two registered read ports, one write port
	logic [31:0] rf_mem [rv32im_pkg::REG_COUNT];
	logic [31:0] rs1_q, rs2_q;
	logic        rf_re;
	logic        rf_we;
	logic [rv32im_pkg::REG_AW-1:0] rf_waddr;
	logic [31:0] rf_wdata;

	// data RAM
	logic [31:0] dm_mem [rv32im_pkg::MEM_WORDS];
	logic [31:0] dm_rdata_q;
	logic        dm_re, dm_we;
	logic [rv32im_pkg::MEM_AW-1:0] dm_addr;
	logic [31:0] dm_wdata;

	logic [rv32im_pkg::MEM_AW-1:0] clr_cnt_q;
	logic clr_last;

	// multiplier and divider
	logic [63:0] prod_q;
	logic [31:0] quo_q, rem_q, dvs_q;
	logic [4:0]  div_cnt_q;
	logic [32:0] div_trial;
	logic        div_start;

	// output register
	logic        out_valid_q;
	logic [31:0] pc_out_q, wb_val_q;
	logic        wb_vld_q;
	rv32im_pkg::status_t sts_q;

	logic accept, out_free, commit;

	// result of the current state
	logic        done;
	logic        go_mem, go_mul, go_div;
	logic        r_wr;
	logic [31:0] r_val, r_pc;
	rv32im_pkg::status_t r_sts;

	// shared operand views
	logic [31:0] a, b, ma, mb, addr, alu_b;
	logic [1:0]  lane;
	logic [4:0]  sh;
	logic [31:0] w_sh, st_mask;
	logic        sa, sb, ovf, mem_illegal, mem_misal;
	logic [31:0] hi, eff_wval;
	logic        eff_wr;

	assign accept    = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != rv32im_pkg::S_IDLE);
	assign clr_last  = (clr_cnt_q == rv32im_pkg::MEM_AW'(rv32im_pkg::MEM_WORDS - 1));

	assign a    = rs1_q;
	assign b    = rs2_q;
	assign sa   = a[31];
	assign sb   = b[31];
	assign ma   = sa ? (~a + 32'd1) : a;
	assign mb   = sb ? (~b + 32'd1) : b;
	assign ovf  = (a == 32'h8000_0000) && (b == 32'hFFFF_FFFF);
	assign addr = a + imm_q;
	assign lane = addr[1:0];
	assign sh   = {lane, 3'b000};
	assign w_sh = dm_rdata_q >> sh;
	assign hi   = prod_q[63:32];

	// Memory access legality, checked in the execute state, and the store mask used by the store write.
	always_comb begin
		mem_illegal = 1'b0;
		mem_misal   = 1'b0;
		st_mask     = 32'h0000_00FF;
		case (f3_q)
			rv32im_pkg::F3_BYTE: st_mask = 32'h0000_00FF;
			rv32im_pkg::F3_HALF: begin
				st_mask   = 32'h0000_FFFF;
				mem_misal = lane[0];
			end
			rv32im_pkg::F3_WORD: begin
				st_mask   = 32'hFFFF_FFFF;
				mem_misal = (lane != 2'd0);
			end
			rv32im_pkg::F3_BYTEU: mem_illegal = (op_q == rv32im_pkg::OPC_STORE);
			rv32im_pkg::F3_HALFU: begin
				mem_illegal = (op_q == rv32im_pkg::OPC_STORE);
				mem_misal   = lane[0];
			end
			default: mem_illegal = 1'b1;
		endcase
		if (mem_illegal) begin
			mem_misal = 1'b0;
		end
	end

	assign div_trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	// Output logic: what the current state produces.
	always_comb begin
		done   = 1'b0;
		go_mem = 1'b0;
		go_mul = 1'b0;
		go_div = 1'b0;
		r_wr   = 1'b0;
		r_val  = 32'd0;
		r_pc   = pc_q;
		r_sts  = rv32im_pkg::STS_OK;
		alu_b  = b;
		case (state_q)
			rv32im_pkg::S_EXEC: begin
				done = 1'b1;
				case (op_q)
					rv32im_pkg::OPC_OP, rv32im_pkg::OPC_OP_IMM: begin
						if (op_q == rv32im_pkg::OPC_OP_IMM) begin
							alu_b = imm_q;
						end
						r_wr = 1'b1;
						if (op_q == rv32im_pkg::OPC_OP && f7_q == rv32im_pkg::F7_MEXT) begin
							done   = 1'b0;
							go_mul = !f3_q[2];
							go_div = f3_q[2];
						end else if (op_q == rv32im_pkg::OPC_OP && f7_q == rv32im_pkg::F7_ALT) begin
							if (f3_q == 3'd0) begin
								r_val = a - b;
							end else if (f3_q == 3'd5) begin
								r_val = 32'($signed(a) >>> b[4:0]);
							end else begin
								r_sts = rv32im_pkg::STS_ILLEGAL;
							end
						end else if (op_q == rv32im_pkg::OPC_OP && f7_q != rv32im_pkg::F7_BASE) begin
							r_sts = rv32im_pkg::STS_ILLEGAL;
						end else begin
							case (f3_q)
								3'd0: r_val = a + alu_b;
								3'd1: begin
									r_val = a << alu_b[4:0];
									if (op_q == rv32im_pkg::OPC_OP_IMM && imm_q[11:5] != 7'd0) begin
										r_sts = rv32im_pkg::STS_ILLEGAL;
									end
								end
								3'd2: r_val = {31'd0, $signed(a) < $signed(alu_b)};
								3'd3: r_val = {31'd0, a < alu_b};
								3'd4: r_val = a ^ alu_b;
								3'd5: begin
									if (op_q == rv32im_pkg::OPC_OP_IMM && imm_q[11:5] == F7_ALT_C) begin
										r_val = 32'($signed(a) >>> alu_b[4:0]);
									end else begin
										r_val = a >> alu_b[4:0];
										if (op_q == rv32im_pkg::OPC_OP_IMM && imm_q[11:5] != 7'd0) begin
											r_sts = rv32im_pkg::STS_ILLEGAL;
										end
									end
								end
								3'd6: r_val = a | alu_b;
								default: r_val = a & alu_b;
							endcase
						end
					end
					rv32im_pkg::OPC_LOAD, rv32im_pkg::OPC_STORE: begin
						if (mem_illegal) begin
							r_sts = rv32im_pkg::STS_ILLEGAL;
						end else if (mem_misal) begin
							r_sts = rv32im_pkg::STS_MISALIGNED;
						end else begin
							done   = 1'b0;
							go_mem = 1'b1;
						end
					end
					rv32im_pkg::OPC_BRANCH: begin
						case (f3_q)
							3'd0: if (a == b) r_pc = pc_q + imm_q - 32'd4;
							3'd1: if (a != b) r_pc = pc_q + imm_q - 32'd4;
							3'd4: if ($signed(a) < $signed(b)) r_pc = pc_q + imm_q - 32'd4;
							3'd5: if ($signed(a) >= $signed(b)) r_pc = pc_q + imm_q - 32'd4;
							3'd6: if (a < b) r_pc = pc_q + imm_q - 32'd4;
							3'd7: if (a >= b) r_pc = pc_q + imm_q - 32'd4;
							default: r_sts = rv32im_pkg::STS_ILLEGAL;
						endcase
					end
					rv32im_pkg::OPC_JAL: begin
						r_wr  = 1'b1;
						r_val = pc_q + 32'd4;
						r_pc  = pc_q + imm_q - 32'd4;
					end
					rv32im_pkg::OPC_JALR: begin
						if (f3_q != 3'd0) begin
							r_sts = rv32im_pkg::STS_ILLEGAL;
						end else begin
							r_wr  = 1'b1;
							r_val = pc_q + 32'd4;
							r_pc  = {addr[31:1], 1'b0} - 32'd4;
						end
					end
					rv32im_pkg::OPC_LUI: begin
						r_wr  = 1'b1;
						r_val = imm_q;
					end
					rv32im_pkg::OPC_AUIPC: begin
						r_wr  = 1'b1;
						r_val = pc_q + imm_q;
					end
					default: r_sts = rv32im_pkg::STS_ILLEGAL;
				endcase
			end
			rv32im_pkg::S_MEM: begin
				done = 1'b1;
				r_wr = (op_q == rv32im_pkg::OPC_LOAD);
				case (f3_q)
					rv32im_pkg::F3_BYTE:  r_val = {{24{w_sh[7]}}, w_sh[7:0]};
					rv32im_pkg::F3_BYTEU: r_val = {24'd0, w_sh[7:0]};
					rv32im_pkg::F3_HALF:  r_val = {{16{w_sh[15]}}, w_sh[15:0]};
					rv32im_pkg::F3_HALFU: r_val = {16'd0, w_sh[15:0]};
					default:              r_val = dm_rdata_q;
				endcase
			end
			rv32im_pkg::S_MULFIN: begin
				done = 1'b1;
				r_wr = 1'b1;
				case (f3_q[1:0])
					2'd0: r_val = prod_q[31:0];
					2'd1: r_val = hi - (sa ? b : 32'd0) - (sb ? a : 32'd0);
					2'd2: r_val = hi - (sa ? b : 32'd0);
					default: r_val = hi;
				endcase
			end
			rv32im_pkg::S_DIVFIN: begin
				done = 1'b1;
				r_wr = 1'b1;
				case (f3_q[1:0])
					2'd0: r_val = (b == 32'd0) ? 32'hFFFF_FFFF :
						ovf ? 32'h8000_0000 : ((sa ^ sb) ? (~quo_q + 32'd1) : quo_q);
					2'd1: r_val = (b == 32'd0) ? 32'hFFFF_FFFF : quo_q;
					2'd2: r_val = (b == 32'd0) ? a :
						ovf ? 32'd0 : (sa ? (~rem_q + 32'd1) : rem_q);
					default: r_val = (b == 32'd0) ? a : rem_q;
				endcase
			end
			default: done = 1'b0;
		endcase
		if (r_sts != rv32im_pkg::STS_OK) begin
			r_wr = 1'b0;
			r_pc = pc_q;
		end
	end

	assign commit    = done && out_free;
	assign eff_wr    = r_wr && (rd_q != 5'd0);
	assign eff_wval  = eff_wr ? r_val : 32'd0;
	assign div_start = (state_q == rv32im_pkg::S_EXEC) && go_div;

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rv32im_pkg::S_CLEAR:  if (clr_last) state_nx = rv32im_pkg::S_IDLE;
			rv32im_pkg::S_IDLE:   if (accept) state_nx = rv32im_pkg::S_EXEC;
			rv32im_pkg::S_EXEC: begin
				if (go_mem) begin
					state_nx = rv32im_pkg::S_MEM;
				end else if (go_mul) begin
					state_nx = rv32im_pkg::S_MULFIN;
				end else if (go_div) begin
					state_nx = rv32im_pkg::S_DIV;
				end else if (commit) begin
					state_nx = rv32im_pkg::S_IDLE;
				end
			end
			rv32im_pkg::S_DIV:    if (div_cnt_q == 5'd31) state_nx = rv32im_pkg::S_DIVFIN;
			rv32im_pkg::S_MEM, rv32im_pkg::S_MULFIN, rv32im_pkg::S_DIVFIN: begin
				if (commit) state_nx = rv32im_pkg::S_IDLE;
			end
			default: state_nx = rv32im_pkg::S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rv32im_pkg::S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == rv32im_pkg::S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Latch the instruction on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			f3_q  <= funct3;
			f7_q  <= funct7;
			rd_q  <= dest_index;
			imm_q <= immediate;
			pc_q  <= pc_in;
		end
	end

	// Register file port control: zero entries during the clearing pass.
	assign rf_re    = accept;
	assign rf_we    = (state_q == rv32im_pkg::S_CLEAR) ?
		(clr_cnt_q[rv32im_pkg::MEM_AW-1:rv32im_pkg::REG_AW] == '0) : (commit && eff_wr);
	assign rf_waddr = (state_q == rv32im_pkg::S_CLEAR) ?
		clr_cnt_q[rv32im_pkg::REG_AW-1:0] : rd_q;
	assign rf_wdata = (state_q == rv32im_pkg::S_CLEAR) ? 32'd0 : r_val;

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_waddr] <= rf_wdata;
		end
		if (rf_re) begin
			rs1_q <= rf_mem[src1_index];
			rs2_q <= rf_mem[src2_index];
		end
	end

	// Data RAM: read in execute, merge and write back on commit of a store.
	assign dm_re    = (state_q == rv32im_pkg::S_EXEC) && go_mem;
	assign dm_we    = (state_q == rv32im_pkg::S_CLEAR) ||
		((state_q == rv32im_pkg::S_MEM) && commit && (op_q == rv32im_pkg::OPC_STORE));
	assign dm_addr  = (state_q == rv32im_pkg::S_CLEAR) ?
		clr_cnt_q : addr[rv32im_pkg::MEM_AW+1:2];
	assign dm_wdata = (state_q == rv32im_pkg::S_CLEAR) ? 32'd0 :
		((dm_rdata_q & ~(st_mask << sh)) | ((b << sh) & (st_mask << sh)));

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dm_mem[dm_addr] <= dm_wdata;
		end
		if (dm_re) begin
			dm_rdata_q <= dm_mem[dm_addr];
		end
	end

	// Multiplier: register the full unsigned product, correct the high half after.
	always_ff @(posedge clk) begin
		if ((state_q == rv32im_pkg::S_EXEC) && go_mul) begin
			prod_q <= {32'd0, a} * {32'd0, b};
		end
	end

	// Restoring divider, one quotient bit per cycle on magnitudes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_start) begin
			div_cnt_q <= '0;
		end else if (state_q == rv32im_pkg::S_DIV) begin
			div_cnt_q <= div_cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			quo_q <= f3_q[0] ? a : ma;
			dvs_q <= f3_q[0] ? b : mb;
			rem_q <= 32'd0;
		end else if (state_q == rv32im_pkg::S_DIV) begin
			if (!div_trial[32]) begin
				rem_q <= div_trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// Output register: hold while stalled, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			pc_out_q <= r_pc;
			wb_vld_q <= eff_wr;
			wb_val_q <= eff_wval;
			sts_q    <= r_sts;
		end
	end

	assign rsp_valid       = out_valid_q;
	assign pc_out          = pc_out_q;
	assign writeback_valid = wb_vld_q;
	assign writeback_value = wb_val_q;
	assign status          = sts_q;

	// x0 is written only by the clearing pass
	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rf_we && state_q != rv32im_pkg::S_CLEAR) |-> (rf_waddr != '0))
		else $error("register x0 written outside clearing pass");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !(out_valid_q && rsp_stall))
		else $error("result committed over a stalled beat");

	// a faulting beat writes no register
	a_fault_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && r_sts != rv32im_pkg::STS_OK) |-> !rf_we)
		else $error("faulting instruction wrote the register file");

	// the divider runs exactly 32 steps before its result
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == rv32im_pkg::S_DIVFIN) |-> ($past(div_cnt_q) == 5'd31))
		else $error("divider finished early");

endmodule
`default_nettype wire
